// ===== sv/skvt_pkg.sv =====
package skvt_pkg;

   // Payload widths of the request and response channels.
   localparam int CMD_W  = 2;
   localparam int KEY_W  = 32;
   localparam int VAL_W  = 32;
   localparam int POS_W  = 8;
   localparam int CNT_W  = 9;
   localparam int STAT_W = 3;

   // Default table depth and register reset values.
   localparam int DEPTH_DEFAULT = 256;
   localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = 9'd256;
   localparam logic [KEY_W-1:0] RESERVED_KEY = 32'hFFFF_FFFF;

   // Register port geometry and register addresses.
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_ENTRIES = 1'b0;

   typedef enum logic [CMD_W-1:0] {
      OP_ADD    = 2'd0,
      OP_FIND   = 2'd1,
      OP_DELETE = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_RESERVED = 3'd2,
      STAT_EMPTY    = 3'd3,
      STAT_BADPOS   = 3'd4,
      STAT_NOTFOUND = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_PROBE,
      S_COMPARE,
      S_SHIFT,
      S_INSERT,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       search_init;
      logic       probe;
      logic       compare;
      logic       shift_init;
      logic       shift_step;
      logic       insert;
      logic       fill_dec;
      logic       set_status;
      status_type status;
      logic       respond;
   } dp_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      op_type op;
      logic   reserved_key;
      logic   full;
      logic   empty;
      logic   bad_pos;
      logic   search_live;
      logic   hit;
      logic   shift_more;
      logic   out_free;
   } dp_stat_type;

endpackage

// ===== sv/skvt_req_if.sv =====
interface skvt_req_if import skvt_pkg::*;;
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [KEY_W-1:0] key;
   logic [VAL_W-1:0] value;
   logic [POS_W-1:0] position;

   modport source (output valid, cmd, key, value, position, input ready);
   modport sink (input valid, cmd, key, value, position, output ready);
endinterface

// ===== sv/skvt_rsp_if.sv =====
interface skvt_rsp_if import skvt_pkg::*;;
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [VAL_W-1:0]  found_value;
   logic [POS_W-1:0]  found_position;
   logic [CNT_W-1:0]  entry_count;

   modport source (output valid, status, found_value, found_position, entry_count,
                   input ready);
   modport sink (input valid, status, found_value, found_position, entry_count,
                 output ready);
endinterface

// ===== sv/skvt_ctrl.sv =====
module skvt_ctrl import skvt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = STAT_OK;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               OP_ADD: begin
                  if (stat.reserved_key) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_RESERVED;
                     state_in       = S_DONE;
                  end else if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_FULL;
                     state_in       = S_DONE;
                  end else begin
                     cmd.search_init = 1'b1;
                     state_in        = S_PROBE;
                  end
               end
               OP_FIND: begin
                  cmd.search_init = 1'b1;
                  state_in        = S_PROBE;
               end
               OP_DELETE: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_EMPTY;
                     state_in       = S_DONE;
                  end else if (stat.bad_pos) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_BADPOS;
                     state_in       = S_DONE;
                  end else begin
                     cmd.shift_init = 1'b1;
                     state_in       = S_SHIFT;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_PROBE: begin
            // Read the midpoint while the search window is open.
            if (stat.search_live) begin
               cmd.probe = 1'b1;
               state_in  = S_COMPARE;
            end else if (stat.op == OP_ADD) begin
               cmd.shift_init = 1'b1;
               state_in       = S_SHIFT;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = STAT_NOTFOUND;
               state_in       = S_DONE;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            if (stat.hit) begin
               state_in = S_DONE;
            end else begin
               state_in = S_PROBE;
            end
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (!stat.shift_more) begin
               if (stat.op == OP_ADD) begin
                  state_in = S_INSERT;
               end else begin
                  cmd.fill_dec = 1'b1;
                  state_in     = S_DONE;
               end
            end
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/skvt_datapath.sv =====
module skvt_datapath import skvt_pkg::*; #(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [KEY_W-1:0]  req_key,
   input  logic [VAL_W-1:0]  req_value,
   input  logic [POS_W-1:0]  req_position,
   input  logic [CNT_W-1:0]  max_entries,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [VAL_W-1:0]  rsp_found_value,
   output logic [POS_W-1:0]  rsp_found_position,
   output logic [CNT_W-1:0]  rsp_entry_count
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int FW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
   localparam int DW = KEY_W + VAL_W;

   // Pair storage: key in the upper half, value in the lower half.
   logic [DW-1:0] mem [TABLE_DEPTH];

   // Request context.
   op_type           op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;
   logic [POS_W-1:0] pos_ff;

   logic [FW-1:0]    fill_ff;
   logic [FW-1:0]    lo_ff, hix_ff, mid_ff, cursor_ff;
   logic             wr_pend_ff, wr_pend_in;
   logic [AW-1:0]    wr_addr_ff;
   logic [DW-1:0]    rdata_ff;
   status_type       status_ff;
   logic [VAL_W-1:0] found_value_ff;
   logic [POS_W-1:0] found_pos_ff;

   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [VAL_W-1:0]  rsp_found_value_ff;
   logic [POS_W-1:0]  rsp_found_position_ff;
   logic [CNT_W-1:0]  rsp_entry_count_ff;

   logic [FW-1:0]    mid;
   logic [KEY_W-1:0] rd_key;
   logic [VAL_W-1:0] rd_val;
   logic             key_lt;
   logic             shift_up;
   logic             shift_more;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [DW-1:0]    wr_data;
   logic [FW-1:0]    cursor_next;

   // Search window midpoint and compare against the word just read.
   assign mid    = lo_ff + ((hix_ff - lo_ff - FW'(1)) >> 1);
   assign rd_key = rdata_ff[DW-1:VAL_W];
   assign rd_val = rdata_ff[VAL_W-1:0];
   assign key_lt = key_ff < rd_key;

   // An add opens a gap at the insertion slot; a delete closes one.
   assign shift_up    = (op_ff == OP_ADD);
   assign shift_more  = shift_up ? (cursor_ff > lo_ff) : ((cursor_ff + FW'(1)) < fill_ff);
   assign cursor_next = shift_up ? (cursor_ff - FW'(1)) : (cursor_ff + FW'(1));
   assign wr_pend_in  = cmd.shift_step && shift_more;

   // Memory port selection.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = mid[AW-1:0];
      if (cmd.probe) begin
         rd_en   = 1'b1;
         rd_addr = mid[AW-1:0];
      end else if (wr_pend_in) begin
         rd_en   = 1'b1;
         rd_addr = cursor_next[AW-1:0];
      end
      wr_en   = wr_pend_ff || cmd.insert;
      wr_addr = wr_pend_ff ? wr_addr_ff : lo_ff[AW-1:0];
      wr_data = wr_pend_ff ? rdata_ff : {key_ff, value_ff};
   end

   // Pair memory, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Status toward the controller.
   always_comb begin
      stat              = '0;
      stat.op           = op_ff;
      stat.reserved_key = (key_ff == RESERVED_KEY);
      stat.full         = (fill_ff >= FW'(max_entries)) || (fill_ff >= FW'(TABLE_DEPTH));
      stat.empty        = (fill_ff == '0);
      stat.bad_pos      = (FW'(pos_ff) >= fill_ff);
      stat.search_live  = (lo_ff < hix_ff);
      stat.hit          = (op_ff == OP_FIND) && (rd_key == key_ff);
      stat.shift_more   = shift_more;
      stat.out_free     = !rsp_valid_ff || rsp_ready;
   end

   // Request capture, search window and shift cursor.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_cmd);
         key_ff   <= req_key;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      if (cmd.search_init) begin
         lo_ff  <= '0;
         hix_ff <= fill_ff;
      end else if (cmd.compare) begin
         if (key_lt) begin
            hix_ff <= mid_ff;
         end else begin
            lo_ff <= mid_ff + FW'(1);
         end
      end
      if (cmd.probe) begin
         mid_ff <= mid;
      end
      if (cmd.shift_init) begin
         cursor_ff <= shift_up ? fill_ff : FW'(pos_ff);
      end else if (wr_pend_in) begin
         cursor_ff <= cursor_next;
      end
      wr_addr_ff <= cursor_ff[AW-1:0];
   end

   // Outcome of the current request.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff      <= STAT_OK;
         found_value_ff <= '0;
         found_pos_ff   <= '0;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
         if (cmd.compare && stat.hit) begin
            found_value_ff <= rd_val;
            found_pos_ff   <= mid_ff[POS_W-1:0];
         end
      end
   end

   // Control registers: fill count and pending shift write.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= wr_pend_in;
         if (cmd.insert) begin
            fill_ff <= fill_ff + FW'(1);
         end else if (cmd.fill_dec) begin
            fill_ff <= fill_ff - FW'(1);
         end
      end
   end

   // Response output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status_ff         <= status_ff;
         rsp_found_value_ff    <= found_value_ff;
         rsp_found_position_ff <= found_pos_ff;
         rsp_entry_count_ff    <= fill_ff[CNT_W-1:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_value    = rsp_found_value_ff;
   assign rsp_found_position = rsp_found_position_ff;
   assign rsp_entry_count    = rsp_entry_count_ff;

endmodule

// ===== sv/sorted_key_value_table_top.sv =====
// Sorted key/value table.
// Requests arrive on req_ch (valid/ready): cmd 0 adds a key/value pair, cmd 1 finds
// a key by binary search, cmd 2 deletes the entry at a sorted position, cmd 3 does
// nothing. Each request gives exactly one response on rsp_ch with a status code,
// the found value and position (zero unless a find hits) and the entry count.
// The table holds pairs in ascending key order; equal keys keep arrival order.
// Register max_entries (byte address 0) limits how many pairs may be held.
// One request is processed at a time. A find is a binary search over the held
// entries; an add searches, then moves every entry behind the insertion point up
// one slot; a delete moves every entry behind the position down one slot.
// The pair memory moves one entry per cycle.
// Reset empties the table and sets max_entries to 256; stored pairs are not
// cleared, only the fill count. The response sits in an output register; while
// the receiver stalls, the next request is still accepted and processed, and its
// response waits until the previous one has been taken.
module sorted_key_value_table_top import skvt_pkg::*; #(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   skvt_req_if.sink              req_ch,
   skvt_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CNT_W-1:0] max_entries_ff;
   dp_cmd_type       ctl_cmd;
   dp_stat_type      dp_stat;
   logic [STAT_W-1:0] rsp_status;

   // Register port: writes complete in the access phase.
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= MAX_ENTRIES_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr == CSR_MAX_ENTRIES)) begin
         max_entries_ff <= csr_pwdata[CNT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == CSR_MAX_ENTRIES) ? CSR_DATA_W'(max_entries_ff) : '0;

   // Sequencer.
   skvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (dp_stat),
      .cmd       (ctl_cmd)
   );

   // Storage, search and shift datapath.
   skvt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_ch.cmd),
      .req_key            (req_ch.key),
      .req_value          (req_ch.value),
      .req_position       (req_ch.position),
      .max_entries        (max_entries_ff),
      .cmd                (ctl_cmd),
      .stat               (dp_stat),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_status         (rsp_status),
      .rsp_found_value    (rsp_ch.found_value),
      .rsp_found_position (rsp_ch.found_position),
      .rsp_entry_count    (rsp_ch.entry_count)
   );

   assign rsp_ch.status = rsp_status;

`ifndef SYNTHESIS
   // A request is processed alone: no second request right after an accept.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while the previous one is in progress");

   // A miss reports no value and no position.
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_status == STAT_NOTFOUND)) |->
      ((rsp_ch.found_value == '0) && (rsp_ch.found_position == '0)))
      else $error("not-found response carries a value or position");

   // The new pair is written only once the gap is fully open.
   a_insert_after_shift: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.insert |-> !dp_stat.shift_more)
      else $error("insert issued while entries still need to move");

   // A response is never loaded over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.respond |-> dp_stat.out_free)
      else $error("response register overwritten before it was taken");
`endif

endmodule

// ===== verif/sorted_key_value_table_top_test.sv =====
`timescale 1ns / 100ps

module sorted_key_value_table_top_test;
   import skvt_pkg::*;

   localparam int TABLE_SIZE  = DEPTH_DEFAULT;
   localparam int STALL_LIMIT = 20000;
   localparam int RECENT_KEYS = 64;

   typedef struct {
      op_type           op;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      logic [POS_W-1:0] position;
   } table_request_type;

   typedef struct {
      status_type       status;
      logic [VAL_W-1:0] value;
      logic [POS_W-1:0] position;
      logic [CNT_W-1:0] count;
   } table_reply_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   skvt_req_if req_ch ();
   skvt_rsp_if rsp_ch ();

   sorted_key_value_table_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predicted table contents and the limit register.
   logic [KEY_W-1:0] table_keys [TABLE_SIZE];
   logic [VAL_W-1:0] table_values [TABLE_SIZE];
   int               table_fill = 0;
   int               entry_limit = int'(MAX_ENTRIES_RESET);

   // Requests waiting to be sent and replies waiting to be checked.
   table_request_type pending_requests[$];
   table_reply_type   expected_replies[$];

   // Fill count as it will stand once every queued request is applied.
   int               queued_fill = 0;
   logic [KEY_W-1:0] recent_keys [RECENT_KEYS];
   int               recent_count = 0;
   int               recent_next = 0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit offer_open = 1'b0;
   int failures = 0;
   int stall_cycles = 0;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one request to the predicted table and returns the reply it should give.
   function automatic table_reply_type apply_to_table(table_request_type r);
      table_reply_type y;
      int slot;
      int lo;
      int hi;
      int mid;
      int i;
      y.status   = STAT_OK;
      y.value    = '0;
      y.position = '0;
      case (r.op)
         OP_ADD: begin
            if (r.key == RESERVED_KEY) begin
               y.status = STAT_RESERVED;
            end else if (table_fill >= entry_limit || table_fill >= TABLE_SIZE) begin
               y.status = STAT_FULL;
            end else begin
               // The new pair lands after every key that is equal or smaller.
               slot = 0;
               while (slot < table_fill && table_keys[slot] <= r.key) slot++;
               for (i = table_fill; i > slot; i--) begin
                  table_keys[i]   = table_keys[i-1];
                  table_values[i] = table_values[i-1];
               end
               table_keys[slot]   = r.key;
               table_values[slot] = r.value;
               table_fill++;
            end
         end
         OP_FIND: begin
            // Midpoint search; the first exact match probed wins.
            y.status = STAT_NOTFOUND;
            lo = 0;
            hi = table_fill - 1;
            while (lo <= hi) begin
               mid = lo + (hi - lo) / 2;
               if (r.key < table_keys[mid]) begin
                  hi = mid - 1;
               end else if (r.key > table_keys[mid]) begin
                  lo = mid + 1;
               end else begin
                  y.status   = STAT_OK;
                  y.value    = table_values[mid];
                  y.position = POS_W'(mid);
                  break;
               end
            end
         end
         OP_DELETE: begin
            if (table_fill == 0) begin
               y.status = STAT_EMPTY;
            end else if (int'(r.position) >= table_fill) begin
               y.status = STAT_BADPOS;
            end else begin
               for (i = int'(r.position); i + 1 < table_fill; i++) begin
                  table_keys[i]   = table_keys[i+1];
                  table_values[i] = table_values[i+1];
               end
               table_fill--;
            end
         end
         default: begin
         end
      endcase
      y.count = CNT_W'(table_fill);
      return y;
   endfunction

   function automatic table_request_type make_request(op_type op, logic [KEY_W-1:0] key,
                                                      logic [VAL_W-1:0] value,
                                                      logic [POS_W-1:0] position);
      table_request_type r;
      r.op       = op;
      r.key      = key;
      r.value    = value;
      r.position = position;
      return r;
   endfunction

   // Keys lean toward a small range so that duplicates and search hits are common.
   function automatic logic [KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(9);
      if (roll < 4) return KEY_W'($urandom_range(15));
      if (roll == 4) begin
         case ($urandom_range(2))
            0: return '0;
            1: return RESERVED_KEY - 1;
            default: return RESERVED_KEY;
         endcase
      end
      return $urandom;
   endfunction

   // Queues a request and tracks the fill count it will leave behind.
   task automatic queue_request(table_request_type r);
      pending_requests.push_back(r);
      if (r.op == OP_ADD && r.key != RESERVED_KEY && queued_fill < entry_limit &&
          queued_fill < TABLE_SIZE) begin
         queued_fill++;
         recent_keys[recent_next] = r.key;
         recent_next = (recent_next + 1) % RECENT_KEYS;
         if (recent_count < RECENT_KEYS) recent_count++;
      end else if (r.op == OP_DELETE && queued_fill > 0 && int'(r.position) < queued_fill) begin
         queued_fill--;
      end
   endtask

   // Random traffic with a given mix of adds and deletes; the rest are finds and no-ops.
   task automatic queue_random(int count, int add_pct, int del_pct);
      table_request_type r;
      int roll;
      repeat (count) begin
         roll       = $urandom_range(99);
         r.key      = pick_key();
         r.value    = $urandom;
         r.position = POS_W'($urandom);
         if (roll < add_pct) r.op = OP_ADD;
         else if (roll < add_pct + del_pct) r.op = OP_DELETE;
         else if (roll < 97) r.op = OP_FIND;
         else r.op = OP_NOP;
         if (r.op == OP_FIND && recent_count > 0 && $urandom_range(1) == 1)
            r.key = recent_keys[$urandom_range(recent_count - 1)];
         if (r.op == OP_DELETE && queued_fill > 0 && $urandom_range(9) < 8)
            r.position = POS_W'($urandom_range(queued_fill - 1));
         queue_request(r);
      end
   endtask

   // Holds off until every queued request has been sent and answered.
   task automatic drain_traffic();
      while (pending_requests.size() != 0 || expected_replies.size() != 0) @(posedge clock);
   endtask

   // Writes max_entries, then reads it back.
   task automatic set_max_entries(logic [CNT_W-1:0] limit);
      logic [CSR_DATA_W-1:0] readback;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_MAX_ENTRIES;
      csr_pwdata  <= CSR_DATA_W'(limit);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      entry_limit = int'(limit);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback[CNT_W-1:0] !== limit) begin
         $error("max_entries: expected %0d, got %0d", limit, readback[CNT_W-1:0]);
         failures++;
      end
   endtask

   // Request driver: holds a request until it is taken, otherwise offers the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!offer_open) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid    <= 1'b1;
            req_ch.cmd      <= pending_requests[0].op;
            req_ch.key      <= pending_requests[0].key;
            req_ch.value    <= pending_requests[0].value;
            req_ch.position <= pending_requests[0].position;
            offer_open = 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response stalls.
   always @(negedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Accepted requests update the predicted table.
   always @(posedge clock) begin : request_accept
      table_request_type taken;
      if (!reset && req_ch.valid && req_ch.ready) begin
         taken = pending_requests.pop_front();
         expected_replies.push_back(apply_to_table(taken));
         offer_open = 1'b0;
      end
   end

   // Response monitor: each response is checked against the oldest prediction.
   always @(posedge clock) begin : reply_check
      table_reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_replies.size() == 0) begin
            $error("response with no request outstanding: status %0d", rsp_ch.status);
            failures++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               failures++;
            end
            if (rsp_ch.found_value !== want.value) begin
               $error("found_value: expected %h, got %h", want.value, rsp_ch.found_value);
               failures++;
            end
            if (rsp_ch.found_position !== want.position) begin
               $error("found_position: expected %0d, got %0d", want.position,
                      rsp_ch.found_position);
               failures++;
            end
            if (rsp_ch.entry_count !== want.count) begin
               $error("entry_count: expected %0d, got %0d", want.count, rsp_ch.entry_count);
               failures++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_psel) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Stimulus sequence.
   initial begin
      int send_mode [3];
      int recv_mode [3];
      send_mode = '{37, 88, 0};
      recv_mode = '{88, 37, 0};

      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.cmd      = OP_NOP;
      req_ch.key      = '0;
      req_ch.value    = '0;
      req_ch.position = '0;
      rsp_ch.ready    = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table cases, reserved key, duplicates and bad positions.
      send_idle_pct = send_mode[0];
      recv_idle_pct = recv_mode[0];
      queue_request(make_request(OP_FIND, 32'd5, $urandom, POS_W'($urandom)));
      queue_request(make_request(OP_DELETE, $urandom, $urandom, 8'd0));
      queue_request(make_request(OP_DELETE, $urandom, $urandom, 8'd255));
      queue_request(make_request(OP_NOP, $urandom, $urandom, POS_W'($urandom)));
      queue_request(make_request(OP_ADD, RESERVED_KEY, 32'h1234_5678, 8'd0));
      queue_request(make_request(OP_ADD, 32'd0, 32'hFFFF_FFFF, 8'd255));
      queue_request(make_request(OP_ADD, RESERVED_KEY - 1, 32'd0, 8'd0));
      queue_request(make_request(OP_ADD, 32'd5, 32'd1, POS_W'($urandom)));
      queue_request(make_request(OP_ADD, 32'd5, 32'd2, POS_W'($urandom)));
      queue_request(make_request(OP_ADD, 32'd5, 32'd3, POS_W'($urandom)));
      queue_request(make_request(OP_FIND, 32'd5, $urandom, POS_W'($urandom)));
      queue_request(make_request(OP_FIND, 32'd0, $urandom, POS_W'($urandom)));
      queue_request(make_request(OP_FIND, RESERVED_KEY - 1, $urandom, POS_W'($urandom)));
      queue_request(make_request(OP_FIND, RESERVED_KEY, $urandom, POS_W'($urandom)));
      queue_request(make_request(OP_FIND, 32'd6, $urandom, POS_W'($urandom)));
      queue_request(make_request(OP_DELETE, $urandom, $urandom, 8'd255));
      queue_request(make_request(OP_DELETE, $urandom, $urandom, 8'd5));
      queue_request(make_request(OP_DELETE, $urandom, $urandom, 8'd4));
      queue_request(make_request(OP_DELETE, $urandom, $urandom, 8'd0));
      drain_traffic();

      // A limit below the present fill blocks adds; the reserved key is still reported first.
      set_max_entries(9'd2);
      queue_request(make_request(OP_ADD, 32'd7, $urandom, POS_W'($urandom)));
      queue_request(make_request(OP_ADD, RESERVED_KEY, $urandom, POS_W'($urandom)));
      queue_request(make_request(OP_DELETE, $urandom, $urandom, 8'd1));
      queue_request(make_request(OP_ADD, 32'd9, $urandom, POS_W'($urandom)));
      queue_request(make_request(OP_DELETE, $urandom, $urandom, 8'd0));
      queue_request(make_request(OP_ADD, 32'd9, $urandom, POS_W'($urandom)));
      drain_traffic();

      // Random traffic under each idling mode: fill up, churn, small limits, then drain.
      for (int m = 0; m < 3; m++) begin
         send_idle_pct = send_mode[m];
         recv_idle_pct = recv_mode[m];
         set_max_entries(9'd256);
         queue_random(320, 88, 4);
         drain_traffic();
         queue_random(80, 30, 30);
         drain_traffic();
         set_max_entries(CNT_W'($urandom_range(1, 8)));
         queue_random(60, 45, 35);
         drain_traffic();
         if (m == 1) set_max_entries(9'd1);
         else set_max_entries(CNT_W'($urandom_range(1, 256)));
         queue_random(56, 20, 60);
         drain_traffic();
      end

      // Allow any stray response to show up before the verdict.
      repeat (300) @(posedge clock);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
